// ===== sv/crfb_pkg.sv =====
// Shared types and constants of the banked stack pointer register file.
package crfb_pkg;

    localparam int unsigned SLOT_COUNT = 17;
    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

    // Slot map of the register memory: data, address, user and supervisor stack pointer.
    localparam logic [SLOT_W-1:0] SLOT_DATA0 = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_ADDR0 = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] SLOT_USP   = SLOT_W'(15);
    localparam logic [SLOT_W-1:0] SLOT_SSP   = SLOT_W'(16);

    localparam logic [31:0] USP_RESET = 32'h00FF_0000;
    localparam logic [31:0] SSP_RESET = 32'h0100_0000;
    localparam logic [15:0] SR_RESET  = 16'h2000;

    localparam logic [3:0] CMD_RDDATA   = 4'd0;
    localparam logic [3:0] CMD_WRDATA   = 4'd1;
    localparam logic [3:0] CMD_RDADDR   = 4'd2;
    localparam logic [3:0] CMD_WRADDR   = 4'd3;
    localparam logic [3:0] CMD_INCADDR  = 4'd4;
    localparam logic [3:0] CMD_DECADDR  = 4'd5;
    localparam logic [3:0] CMD_EVALCOND = 4'd6;
    localparam logic [3:0] CMD_SETPC    = 4'd7;
    localparam logic [3:0] CMD_RDPC     = 4'd8;
    localparam logic [3:0] CMD_WRSR     = 4'd9;
    localparam logic [3:0] CMD_RDSR     = 4'd10;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_NONE = 2'd3;

    localparam logic [3:0] CC_T  = 4'd0;
    localparam logic [3:0] CC_F  = 4'd1;
    localparam logic [3:0] CC_HI = 4'd2;
    localparam logic [3:0] CC_LS = 4'd3;
    localparam logic [3:0] CC_CC = 4'd4;
    localparam logic [3:0] CC_CS = 4'd5;
    localparam logic [3:0] CC_NE = 4'd6;
    localparam logic [3:0] CC_EQ = 4'd7;
    localparam logic [3:0] CC_VC = 4'd8;
    localparam logic [3:0] CC_VS = 4'd9;
    localparam logic [3:0] CC_PL = 4'd10;
    localparam logic [3:0] CC_MI = 4'd11;
    localparam logic [3:0] CC_GE = 4'd12;
    localparam logic [3:0] CC_LT = 4'd13;
    localparam logic [3:0] CC_GT = 4'd14;
    localparam logic [3:0] CC_LE = 4'd15;

    localparam int unsigned SR_C_BIT = 0;
    localparam int unsigned SR_V_BIT = 1;
    localparam int unsigned SR_Z_BIT = 2;
    localparam int unsigned SR_N_BIT = 3;
    localparam int unsigned SR_S_BIT = 13;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       data;
    } wr_req_t;

    function automatic logic [31:0] slot_reset(input logic [SLOT_W-1:0] slot);
        logic [31:0] value;
        value = 32'h0000_0000;
        if (slot == SLOT_USP) value = USP_RESET;
        if (slot == SLOT_SSP) value = SSP_RESET;
        return value;
    endfunction

endpackage

// ===== sv/crfb_regmem.sv =====
// Register memory holding the data, address and stack pointer registers.
module crfb_regmem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [crfb_pkg::SLOT_W-1:0] rd_addr,
    input  crfb_pkg::wr_req_t          wr,
    output logic [31:0]                rd_data
);

    logic [31:0]                   mem [crfb_pkg::SLOT_COUNT];
    logic [31:0]                   rd_raw_reg;
    logic [crfb_pkg::SLOT_COUNT-1:0] valid_reg;
    logic                          rd_hit_reg;
    logic [crfb_pkg::SLOT_W-1:0]   rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // An entry that was never written reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_hit_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_hit_reg  <= valid_reg[rd_addr];
                rd_addr_reg <= rd_addr;
            end
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : crfb_pkg::slot_reset(rd_addr_reg);

endmodule

// ===== sv/cpu_register_file_banked_sp.sv =====
// Top level of the 68000-style register file with banked stack pointer.
//
// Requests arrive on the req channel (req_valid/req_ready) and carry cmd,
// reg_index, op_size, write_value and cond_code. Every request gives one
// response on the rsp channel (rsp_valid/rsp_ready) with read_value and
// cond_true; both are zero where the command reads nothing.
// A request is handled in a read step and an execute step: in the cycle it
// is accepted the register memory is read, and in the execute step the
// value is modified, written back and the response register is loaded.
// The execute step waits while the response register is full and not
// taken; no new request is accepted until the execute step is done.
// A new request is accepted while an earlier response still waits; if the
// receiver stalls, the block holds the second request in its execute step
// until the response register is free.
// Reset clears the registers to their reset values at once: data and
// address registers zero, user stack 0x00FF0000, supervisor stack
// 0x01000000, program counter zero, status register 0x2000.
module cpu_register_file_banked_sp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [3:0]  cmd,
    input  logic [2:0]  reg_index,
    input  logic [1:0]  op_size,
    input  logic [31:0] write_value,
    input  logic [3:0]  cond_code,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] read_value,
    output logic        cond_true
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                      state_reg;
    logic [3:0]                  cmd_reg;
    logic [1:0]                  size_reg;
    logic [31:0]                 value_reg;
    logic [3:0]                  cc_reg;
    logic [crfb_pkg::SLOT_W-1:0] slot_reg;
    logic [31:0]                 pc_reg;
    logic [15:0]                 sr_reg;
    logic                        rsp_valid_reg;
    logic [31:0]                 read_value_reg;
    logic                        cond_true_reg;

    logic                        accept;
    logic                        exec_go;
    logic [crfb_pkg::SLOT_W-1:0] slot_next;
    logic [31:0]                 rd_data;
    logic [31:0]                 merged;
    logic [31:0]                 step;
    logic                        cond_next;
    logic [31:0]                 read_value_next;
    crfb_pkg::wr_req_t           wr;

    logic flag_c;
    logic flag_v;
    logic flag_z;
    logic flag_n;

    crfb_regmem u_regmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (slot_next),
        .wr      (wr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign exec_go   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // Address register seven follows the supervisor bit at the time of the request.
    always_comb
    begin
        if (cmd inside {crfb_pkg::CMD_RDDATA, crfb_pkg::CMD_WRDATA})
        begin
            slot_next = crfb_pkg::SLOT_DATA0 + crfb_pkg::SLOT_W'(reg_index);
        end
        else if (reg_index != 3'd7)
        begin
            slot_next = crfb_pkg::SLOT_ADDR0 + crfb_pkg::SLOT_W'(reg_index);
        end
        else if (sr_reg[crfb_pkg::SR_S_BIT])
        begin
            slot_next = crfb_pkg::SLOT_SSP;
        end
        else
        begin
            slot_next = crfb_pkg::SLOT_USP;
        end
    end

    always_comb
    begin
        case (size_reg)
            crfb_pkg::SIZE_BYTE: merged = {rd_data[31:8], value_reg[7:0]};
            crfb_pkg::SIZE_WORD: merged = {rd_data[31:16], value_reg[15:0]};
            crfb_pkg::SIZE_LONG: merged = value_reg;
            default:             merged = rd_data;
        endcase
    end

    always_comb
    begin
        case (size_reg)
            crfb_pkg::SIZE_WORD: step = 32'd2;
            crfb_pkg::SIZE_LONG: step = 32'd4;
            default:             step = 32'd1;
        endcase
    end

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = slot_reg;
        wr.data = merged;
        if (cmd_reg inside {crfb_pkg::CMD_WRDATA, crfb_pkg::CMD_WRADDR})
        begin
            wr.en = exec_go;
        end
        else if (cmd_reg == crfb_pkg::CMD_INCADDR)
        begin
            wr.en   = exec_go;
            wr.data = rd_data + step;
        end
        else if (cmd_reg == crfb_pkg::CMD_DECADDR)
        begin
            wr.en   = exec_go;
            wr.data = rd_data - step;
        end
    end

    assign flag_c = sr_reg[crfb_pkg::SR_C_BIT];
    assign flag_v = sr_reg[crfb_pkg::SR_V_BIT];
    assign flag_z = sr_reg[crfb_pkg::SR_Z_BIT];
    assign flag_n = sr_reg[crfb_pkg::SR_N_BIT];

    always_comb
    begin
        case (cc_reg)
            crfb_pkg::CC_T:  cond_next = 1'b1;
            crfb_pkg::CC_F:  cond_next = 1'b0;
            crfb_pkg::CC_HI: cond_next = !flag_z && !flag_c;
            crfb_pkg::CC_LS: cond_next = flag_z || flag_c;
            crfb_pkg::CC_CC: cond_next = !flag_c;
            crfb_pkg::CC_CS: cond_next = flag_c;
            crfb_pkg::CC_NE: cond_next = !flag_z;
            crfb_pkg::CC_EQ: cond_next = flag_z;
            crfb_pkg::CC_VC: cond_next = !flag_v;
            crfb_pkg::CC_VS: cond_next = flag_v;
            crfb_pkg::CC_PL: cond_next = !flag_n;
            crfb_pkg::CC_MI: cond_next = flag_n;
            crfb_pkg::CC_GE: cond_next = (flag_n == flag_v);
            crfb_pkg::CC_LT: cond_next = (flag_n != flag_v);
            crfb_pkg::CC_GT: cond_next = !flag_z && (flag_n == flag_v);
            default:         cond_next = flag_z || (flag_n != flag_v);
        endcase
    end

    always_comb
    begin
        case (cmd_reg)
            crfb_pkg::CMD_RDDATA, crfb_pkg::CMD_RDADDR: read_value_next = rd_data;
            crfb_pkg::CMD_RDPC:                         read_value_next = pc_reg;
            crfb_pkg::CMD_RDSR:                         read_value_next = {16'h0000, sr_reg};
            default:                                    read_value_next = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= crfb_pkg::CMD_RDDATA;
            size_reg       <= crfb_pkg::SIZE_BYTE;
            value_reg      <= '0;
            cc_reg         <= crfb_pkg::CC_T;
            slot_reg       <= '0;
            pc_reg         <= '0;
            sr_reg         <= crfb_pkg::SR_RESET;
            rsp_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            cond_true_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !exec_go)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= cmd;
                        size_reg  <= op_size;
                        value_reg <= write_value;
                        cc_reg    <= cond_code;
                        slot_reg  <= slot_next;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        if (cmd_reg == crfb_pkg::CMD_SETPC)
                        begin
                            pc_reg <= value_reg;
                        end
                        if (cmd_reg == crfb_pkg::CMD_WRSR)
                        begin
                            sr_reg <= value_reg[15:0];
                        end
                        rsp_valid_reg  <= 1'b1;
                        read_value_reg <= read_value_next;
                        cond_true_reg  <= (cmd_reg == crfb_pkg::CMD_EVALCOND) && cond_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign cond_true  = cond_true_reg;

endmodule

// ===== tb/cpu_register_file_banked_sp_tb.sv =====
// Self-checking testbench of the register file with banked stack pointer.
module cpu_register_file_banked_sp_tb;

    localparam logic [3:0] CMD_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

    localparam logic [2:0] SP_INDEX = 3'd7;

    localparam int RANDOM_ITEMS   = 950;
    localparam int CALM_TAIL      = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [2:0]  idx;
        logic [1:0]  size;
        logic [31:0] value;
        logic [3:0]  cc;
    } request_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        cond_true;
    } response_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    logic [3:0]  cmd         = '0;
    logic [2:0]  reg_index   = '0;
    logic [1:0]  op_size     = '0;
    logic [31:0] write_value = '0;
    logic [3:0]  cond_code   = '0;
    logic        rsp_ready   = 1'b0;
    logic        req_ready;
    logic        rsp_valid;
    logic [31:0] read_value;
    logic        cond_true;

    cpu_register_file_banked_sp uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .reg_index   (reg_index),
        .op_size     (op_size),
        .write_value (write_value),
        .cond_code   (cond_code),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .read_value  (read_value),
        .cond_true   (cond_true)
    );

    // Shadow copy of the architectural state.
    logic [31:0] data_file [8];
    logic [31:0] addr_file [7];
    logic [31:0] user_stack;
    logic [31:0] super_stack;
    logic [31:0] pc_shadow;
    logic [15:0] sr_shadow;

    request_t  pending_req [$];
    response_t expected_rsp [$];
    request_t  issue_req;
    response_t predicted;
    response_t oldest;

    int total_items   = 0;
    int accepted_reqs = 0;
    int checked_rsps  = 0;
    int cond_tests    = 0;
    int super_sp_uses = 0;
    int user_sp_uses  = 0;
    int mismatches    = 0;
    int req_gap       = 0;
    int rsp_gap       = 0;
    int idle_cycles   = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic reset_shadow();
        foreach (data_file[i]) data_file[i] = '0;
        foreach (addr_file[i]) addr_file[i] = '0;
        user_stack  = crfb_pkg::USP_RESET;
        super_stack = crfb_pkg::SSP_RESET;
        pc_shadow   = '0;
        sr_shadow   = crfb_pkg::SR_RESET;
    endtask

    function automatic logic [31:0] merge_part(input logic [31:0] old, input logic [31:0] val,
                                               input logic [1:0] size);
        case (size)
            crfb_pkg::SIZE_BYTE: return {old[31:8], val[7:0]};
            crfb_pkg::SIZE_WORD: return {old[31:16], val[15:0]};
            crfb_pkg::SIZE_LONG: return val;
            default:             return old;
        endcase
    endfunction

    // Address register 7 follows the supervisor bit at the time of the request.
    function automatic logic [31:0] addr_read(input logic [2:0] idx);
        if (idx != SP_INDEX) return addr_file[idx];
        return sr_shadow[crfb_pkg::SR_S_BIT] ? super_stack : user_stack;
    endfunction

    task automatic addr_write(input logic [2:0] idx, input logic [31:0] val);
        if (idx != SP_INDEX)
        begin
            addr_file[idx] = val;
        end
        else if (sr_shadow[crfb_pkg::SR_S_BIT])
        begin
            super_stack = val;
            super_sp_uses++;
        end
        else
        begin
            user_stack = val;
            user_sp_uses++;
        end
    endtask

    function automatic logic condition_holds(input logic [3:0] cc);
        logic c, v, z, n;
        c = sr_shadow[crfb_pkg::SR_C_BIT];
        v = sr_shadow[crfb_pkg::SR_V_BIT];
        z = sr_shadow[crfb_pkg::SR_Z_BIT];
        n = sr_shadow[crfb_pkg::SR_N_BIT];
        case (cc)
            crfb_pkg::CC_T:  return 1'b1;
            crfb_pkg::CC_F:  return 1'b0;
            crfb_pkg::CC_HI: return !z && !c;
            crfb_pkg::CC_LS: return z || c;
            crfb_pkg::CC_CC: return !c;
            crfb_pkg::CC_CS: return c;
            crfb_pkg::CC_NE: return !z;
            crfb_pkg::CC_EQ: return z;
            crfb_pkg::CC_VC: return !v;
            crfb_pkg::CC_VS: return v;
            crfb_pkg::CC_PL: return !n;
            crfb_pkg::CC_MI: return n;
            crfb_pkg::CC_GE: return n == v;
            crfb_pkg::CC_LT: return n != v;
            crfb_pkg::CC_GT: return !z && (n == v);
            default:         return z || (n != v);
        endcase
    endfunction

    task automatic execute_request(input request_t r, output response_t rsp);
        logic [31:0] step_by;
        rsp = '0;
        step_by = (r.size == crfb_pkg::SIZE_LONG) ? 32'd4 :
                  (r.size == crfb_pkg::SIZE_WORD) ? 32'd2 : 32'd1;
        case (r.cmd)
            crfb_pkg::CMD_RDDATA:  rsp.read_value = data_file[r.idx];
            crfb_pkg::CMD_WRDATA:  data_file[r.idx] = merge_part(data_file[r.idx], r.value,
                                                                 r.size);
            crfb_pkg::CMD_RDADDR:  rsp.read_value = addr_read(r.idx);
            crfb_pkg::CMD_WRADDR:  addr_write(r.idx, merge_part(addr_read(r.idx), r.value,
                                                                r.size));
            crfb_pkg::CMD_INCADDR: addr_write(r.idx, addr_read(r.idx) + step_by);
            crfb_pkg::CMD_DECADDR: addr_write(r.idx, addr_read(r.idx) - step_by);
            crfb_pkg::CMD_EVALCOND:
            begin
                rsp.cond_true = condition_holds(r.cc);
                cond_tests++;
            end
            crfb_pkg::CMD_SETPC:   pc_shadow = r.value;
            crfb_pkg::CMD_RDPC:    rsp.read_value = pc_shadow;
            crfb_pkg::CMD_WRSR:    sr_shadow = r.value[15:0];
            crfb_pkg::CMD_RDSR:    rsp.read_value = {16'h0000, sr_shadow};
            default:               ;
        endcase
    endtask

    function automatic request_t make_req(input logic [3:0] c, input logic [2:0] idx,
                                          input logic [1:0] size, input logic [31:0] val,
                                          input logic [3:0] cc);
        request_t r;
        r.cmd   = c;
        r.idx   = idx;
        r.size  = size;
        r.value = val;
        r.cc    = cc;
        return r;
    endfunction

    function automatic request_t random_req();
        request_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) r.cmd = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        else          r.cmd = 4'($urandom_range(crfb_pkg::CMD_RDDATA, crfb_pkg::CMD_RDSR));
        r.idx  = 3'($urandom_range(0, 7));
        r.size = ($urandom_range(0, 9) == 0) ? crfb_pkg::SIZE_NONE :
                 2'($urandom_range(crfb_pkg::SIZE_BYTE, crfb_pkg::SIZE_LONG));
        case ($urandom_range(0, 5))
            0:       r.value = '0;
            1:       r.value = '1;
            2:       r.value = 32'($urandom_range(0, 15));
            default: r.value = $urandom;
        endcase
        r.cc = 4'($urandom_range(crfb_pkg::CC_T, crfb_pkg::CC_LE));
        return r;
    endfunction

    // Idling is switched off in every third stretch of 64 requests and near the end.
    function automatic bit idling_allowed();
        return (accepted_reqs < total_items - CALM_TAIL) && ((accepted_reqs / 64) % 3 != 2);
    endfunction

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (req_gap > 0)
            begin
                req_gap   <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 11) == 0)
            begin
                req_gap   <= $urandom_range(0, 12);
                req_valid <= 1'b0;
            end
            else if (pending_req.size() != 0)
            begin
                issue_req    = pending_req.pop_front();
                req_valid   <= 1'b1;
                cmd         <= issue_req.cmd;
                reg_index   <= issue_req.idx;
                op_size     <= issue_req.size;
                write_value <= issue_req.value;
                cond_code   <= issue_req.cc;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
        end
        else if (idling_allowed() && $urandom_range(0, 9) == 0)
        begin
            rsp_gap   <= $urandom_range(0, 12);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted response.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_shadow();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                execute_request({cmd, reg_index, op_size, write_value, cond_code}, predicted);
                expected_rsp.push_back(predicted);
                accepted_reqs++;
            end
            if (rsp_valid && rsp_ready)
            begin
                checked_rsps++;
                if (expected_rsp.size() == 0)
                begin
                    report("response with no request outstanding");
                end
                else
                begin
                    oldest = expected_rsp.pop_front();
                    if (read_value !== oldest.read_value)
                        report($sformatf("read_value %h, expected %h",
                                         read_value, oldest.read_value));
                    if (cond_true !== oldest.cond_true)
                        report($sformatf("cond_true %b, expected %b",
                                         cond_true, oldest.cond_true));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("cpu_register_file_banked_sp_tb NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        // Reset values, sized merges, a write of no size and wraparound of a step.
        pending_req.push_back(make_req(crfb_pkg::CMD_RDADDR, SP_INDEX, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDSR, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRDATA, 3'd0, crfb_pkg::SIZE_LONG,
                                       '1, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRDATA, 3'd0, crfb_pkg::SIZE_BYTE,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRDATA, 3'd0, crfb_pkg::SIZE_WORD,
                                       32'h1234_5678, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRDATA, 3'd0, crfb_pkg::SIZE_NONE,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDDATA, 3'd0, crfb_pkg::SIZE_NONE,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_DECADDR, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_INCADDR, 3'd0, crfb_pkg::SIZE_NONE,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDADDR, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        // Drop to user mode with every flag set, then use the user stack pointer.
        pending_req.push_back(make_req(crfb_pkg::CMD_WRSR, 3'd0, crfb_pkg::SIZE_LONG,
                                       32'hFFFF_000F, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_INCADDR, SP_INDEX, crfb_pkg::SIZE_WORD,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRADDR, SP_INDEX, crfb_pkg::SIZE_BYTE,
                                       '1, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDADDR, SP_INDEX, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_EVALCOND, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_GE));
        pending_req.push_back(make_req(crfb_pkg::CMD_EVALCOND, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_LT));
        pending_req.push_back(make_req(crfb_pkg::CMD_EVALCOND, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_GT));
        pending_req.push_back(make_req(crfb_pkg::CMD_EVALCOND, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_LE));
        pending_req.push_back(make_req(crfb_pkg::CMD_WRSR, 3'd0, crfb_pkg::SIZE_LONG,
                                       '1, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDSR, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDADDR, SP_INDEX, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_SETPC, 3'd0, crfb_pkg::SIZE_LONG,
                                       '1, crfb_pkg::CC_T));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDPC, 3'd0, crfb_pkg::SIZE_LONG,
                                       '0, crfb_pkg::CC_T));
        pending_req.push_back(make_req(CMD_UNUSED_LAST, 3'd7, crfb_pkg::SIZE_NONE,
                                       '1, crfb_pkg::CC_LE));
        pending_req.push_back(make_req(crfb_pkg::CMD_RDDATA, 3'd7, crfb_pkg::SIZE_BYTE,
                                       '0, crfb_pkg::CC_T));
        repeat (RANDOM_ITEMS) pending_req.push_back(random_req());
        total_items = pending_req.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled between edges so that every update of the last edge is seen.
        do @(negedge clk);
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d responses checked, %0d condition tests",
                 accepted_reqs, checked_rsps, cond_tests);
        $display("stack pointer updates: %0d supervisor, %0d user; %0d mismatches",
                 super_sp_uses, user_sp_uses, mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0 && checked_rsps == accepted_reqs)
        begin
            $display("cpu_register_file_banked_sp_tb OK");
        end
        else
        begin
            $display("cpu_register_file_banked_sp_tb NOT OK");
        end
        $finish;
    end

endmodule
